### sv/palette_rotated_blitter_unit_assert.svh
// ----------------------------------------------------------------------------
// palette_rotated_blitter_unit_assert.svh
// Assertion macros used by the blitter RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_ROTATED_BLITTER_UNIT_ASSERT_SVH
`define PALETTE_ROTATED_BLITTER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define PRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define PRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Types and codes for the palette rotated blitter.
// ----------------------------------------------------------------------------
package prb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int ADDR_W     = 19;
  localparam int RGB_W      = 24;

  typedef enum logic [1:0] {
    ACT_PAL_WRITE  = 2'd0,
    ACT_PAL_COMMIT = 2'd1,
    ACT_FRAME      = 2'd2,
    ACT_PIXEL      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    FMT_BGR8     = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_RGBA8888 = 2'd2,
    FMT_RSVD     = 2'd3
  } pix_fmt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_HEIGHT  = 2'd2;

  localparam logic [8:0] BLIT_WIDTH_RST  = 9'd320;
  localparam logic [7:0] BLIT_HEIGHT_RST = 8'd240;

  typedef struct packed {
    action_t    action;
    logic [7:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [31:0]       pixel_word;
  } out_beat_t;

endpackage

### sv/palette_rotated_blitter_unit.sv
// ----------------------------------------------------------------------------
// palette_rotated_blitter_unit
// Palette lookup of indexed pixels with a 90 degree rotated framebuffer write.
// ----------------------------------------------------------------------------
// Takes one input beat per clock unless stage 1 and the output register are
// both full and out_ready is low. The accepting edge reads the palette RAM
// (one read port, one index per clock) and registers the rotated element
// offset in stage 1; once the output register is free or draining, the color
// is packed and the offset scaled into the output register. Palette writes,
// commits, frame starts and dropped pixels give no output beat. The palette
// holds no reset value; read only entries written.
// ----------------------------------------------------------------------------
`include "palette_rotated_blitter_unit_assert.svh"

module palette_rotated_blitter_unit #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int SCREEN_ROWS     = 320,
  parameter int SCREEN_COLS     = 240
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  prb_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output prb_pkg::out_beat_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [prb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int ROW_W   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int DX_W    = (ROW_W > 9) ? ROW_W : 9;
  localparam int ELEM_W  = (SCREEN_ROWS * SCREEN_COLS > 1) ?
                           $clog2(SCREEN_ROWS * SCREEN_COLS) : 1;
  localparam int PROD_W  = ELEM_W + 2;
  localparam int EXT_W   = (PROD_W > prb_pkg::ADDR_W) ? PROD_W : prb_pkg::ADDR_W;
  localparam int CMP_W   = 12;

  // config
  prb_pkg::pix_fmt_t fmt_r;
  logic [8:0]        blit_w_r;
  logic [7:0]        blit_h_r;

  // raster state
  logic       armed_r, armed_nxt;
  logic [8:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  // stage 1
  logic                 s1_v_r, s1_v_nxt;
  logic [ELEM_W-1:0]    s1_elem_r;
  prb_pkg::pix_fmt_t    s1_fmt_r;

  // output
  logic                 out_valid_r;
  prb_pkg::out_beat_t   out_data_r, out_data_nxt;

  logic in_fire, s1_go, is_pixel, draw;
  logic [8:0]        col_inc;
  logic [DX_W-1:0]   rx;
  logic [ELEM_W-1:0] elem;
  logic [PAL_AW-1:0] pal_addr;
  logic [PAL_AW-1:0] idx_map [256];
  logic [prb_pkg::RGB_W-1:0] rgb;
  logic [7:0]        r8, g8, b8;
  logic [EXT_W-1:0]  e_ext, prod;

  // index wrap table (constant)
  for (genvar i = 0; i < 256; i++) begin : g_idx
    assign idx_map[i] = PAL_AW'(i % PALETTE_ENTRIES);
  end

  assign s1_go     = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_v_r || !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign pal_addr  = idx_map[in_data.color_index];
  assign is_pixel  = in_data.action == prb_pkg::ACT_PIXEL;

  always_comb begin
    col_inc = col_r + 9'd1;
    draw = armed_r && (blit_w_r != 9'd0)
        && (col_r < blit_w_r) && (CMP_W'(col_r) < CMP_W'(SCREEN_ROWS))
        && (row_r < blit_h_r) && (CMP_W'(row_r) < CMP_W'(SCREEN_COLS));
    rx   = DX_W'(SCREEN_ROWS - 1) - DX_W'(col_r);
    elem = ELEM_W'(ELEM_W'(rx) * ELEM_W'(SCREEN_COLS)) + ELEM_W'(row_r);

    armed_nxt = armed_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    s1_v_nxt  = s1_v_r && !s1_go;
    if (in_fire) begin
      case (in_data.action)
        prb_pkg::ACT_PAL_COMMIT: begin
          armed_nxt = 1'b1;
        end
        prb_pkg::ACT_FRAME: begin
          col_nxt = 9'd0;
          row_nxt = 8'd0;
        end
        prb_pkg::ACT_PIXEL: begin
          if (blit_w_r != 9'd0) begin
            s1_v_nxt = draw;
            if (col_inc >= blit_w_r) begin
              col_nxt = 9'd0;
              if (row_r != 8'hFF) begin
                row_nxt = row_r + 8'd1;
              end
            end else begin
              col_nxt = col_inc;
            end
          end else begin
            s1_v_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  prb_ram #(
    .WIDTH (prb_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (in_fire && (in_data.action == prb_pkg::ACT_PAL_WRITE)),
    .wr_addr (pal_addr),
    .wr_data ({in_data.red, in_data.green, in_data.blue}),
    .rd_en   (in_fire && is_pixel),
    .rd_addr (pal_addr),
    .rd_data (rgb)
  );

  always_comb begin
    r8 = rgb[23:16];
    g8 = rgb[15:8];
    b8 = rgb[7:0];
    e_ext = EXT_W'(s1_elem_r);
    case (s1_fmt_r)
      prb_pkg::FMT_BGR8: begin
        prod = e_ext + (e_ext << 1);
        out_data_nxt.pixel_word = {8'h00, r8, g8, b8};
      end
      prb_pkg::FMT_RGB565: begin
        prod = e_ext << 1;
        out_data_nxt.pixel_word = {16'h0000, r8[7:3], g8[7:2], b8[7:3]};
      end
      default: begin
        prod = e_ext << 2;
        out_data_nxt.pixel_word = {r8, g8, b8, 8'hFF};
      end
    endcase
    out_data_nxt.byte_address = prod[prb_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= prb_pkg::FMT_BGR8;
      blit_w_r    <= prb_pkg::BLIT_WIDTH_RST;
      blit_h_r    <= prb_pkg::BLIT_HEIGHT_RST;
      armed_r     <= 1'b0;
      col_r       <= 9'd0;
      row_r       <= 8'd0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          prb_pkg::CFG_PIXEL_FORMAT: fmt_r    <= prb_pkg::pix_fmt_t'(cfg_data[1:0]);
          prb_pkg::CFG_BLIT_WIDTH:   blit_w_r <= cfg_data;
          prb_pkg::CFG_BLIT_HEIGHT:  blit_h_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      armed_r <= armed_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      s1_v_r  <= s1_v_nxt;
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_pixel) begin
      s1_elem_r <= elem;
      s1_fmt_r  <= fmt_r;
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PRB_ASSERT_NEXT(a_non_pixel_no_s1, in_fire && !is_pixel, !s1_v_r, "non-pixel beat staged")
  `PRB_ASSERT_NEXT(a_unarmed_drop, in_fire && is_pixel && !armed_r, !s1_v_r, "unarmed pixel staged")
  `PRB_ASSERT_NEXT(a_frame_clear, in_fire && (in_data.action == prb_pkg::ACT_FRAME), (col_r == 9'd0) && (row_r == 8'd0), "frame start left counters")
  `PRB_ASSERT_NOW(a_full_stall, s1_v_r && out_valid_r && !out_ready, !in_ready, "accepted into full pipe")
  `PRB_ASSERT_NEXT(a_s1_to_out, s1_go, out_valid_r, "staged pixel lost")

endmodule

### sv/prb_ram.sv
// ----------------------------------------------------------------------------
// prb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
